FILE: rtl/rmes_pkg.sv
// Shared types, constants and opcodes for the register machine step block.
// No dependencies.
`default_nettype none
package rmes_pkg;
   localparam int MemBytes = 4096;
   localparam int AddrW = $clog2(MemBytes);
   localparam int NumRegs = 13;
   localparam int RegW = $clog2(NumRegs);
   localparam int IdxW = 4;

   localparam logic [1:0] OP_LOAD = 2'd0;
   localparam logic [1:0] OP_START = 2'd1;
   localparam logic [1:0] OP_STEP = 2'd2;

   localparam logic [2:0] ST_OK = 3'd0;
   localparam logic [2:0] ST_BAD_OP = 3'd1;
   localparam logic [2:0] ST_UNIMPL = 3'd2;
   localparam logic [2:0] ST_DIV_ZERO = 3'd3;
   localparam logic [2:0] ST_BAD_ARG = 3'd4;

   localparam logic [1:0] CK_NONE = 2'd0;
   localparam logic [1:0] CK_INT = 2'd1;
   localparam logic [1:0] CK_CHAR = 2'd2;
   localparam logic [1:0] CK_NL = 2'd3;

   localparam logic [IdxW-1:0] REG_PC = 4'd8;
   localparam logic [IdxW-1:0] REG_LIM = 4'd9;
   localparam logic [IdxW-1:0] REG_SP = 4'd10;
   localparam logic [IdxW-1:0] REG_BASE = 4'd12;
   localparam logic [IdxW-1:0] REG_CON = 4'd3;

   localparam logic CSR_START = 1'b0;
   localparam logic CSR_END = 1'b1;

   localparam int StackMargin = 32;
   localparam int TrapNl = 99;

   // controller -> datapath
   typedef struct packed {
      logic capture;
      logic mem_load;
      logic start;
      logic fetch_addr;
      logic fetch_byte;
      logic exec;
      logic mem_addr;
      logic mem_byte;
      logic div_start;
      logic div_step;
      logic commit;
      logic clr_out;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic halted;
      logic is_div;
      logic is_load;
      logic is_store;
      logic [2:0] nbytes;
      logic div_done;
   } sts_type;
endpackage
`default_nettype wire

FILE: rtl/register_machine_execute_step.sv
// Top level of the register machine step block: controller plus datapath.
// Depends on rmes_pkg, rmes_ctrl, rmes_dp.
//
//  channel | dir | ports
//  req     | in  | req_valid/req_stall, operation, mem_address, mem_byte, console_value
//  rsp     | out | rsp_valid/rsp_stall, program_counter ... stack_underflow
//  csr     | in  | csr_write, csr_index, csr_data
//
// A step fetches its 12 bytes over the one byte-wide memory port, then accesses
// memory for load and store operands or runs the serial divider for a divide.
// After reset the memory is cleared to zero; requests stall meanwhile.
// A held result stalls the next request until it is taken.
`default_nettype none
module register_machine_execute_step (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   output logic req_stall,
   input wire logic [1:0] req_operation,
   input wire logic [11:0] req_mem_address,
   input wire logic [7:0] req_mem_byte,
   input wire logic signed [31:0] req_console_value,
   output logic rsp_valid,
   input wire logic rsp_stall,
   output logic [11:0] rsp_program_counter,
   output logic rsp_halted,
   output logic [1:0] rsp_console_kind,
   output logic signed [31:0] rsp_console_out,
   output logic rsp_input_taken,
   output logic [2:0] rsp_status,
   output logic rsp_stack_overflow,
   output logic rsp_stack_underflow,
   input wire logic csr_write,
   input wire logic csr_index,
   input wire logic [11:0] csr_data
);
   import rmes_pkg::*;

   cmd_type cmd;
   sts_type sts;
   logic clear_done;

   rmes_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
      .req_operation(req_operation), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .clear_done(clear_done), .cmd(cmd), .sts(sts)
   );

   rmes_dp u_dp (
      .clock(clock), .reset(reset), .req_operation(req_operation),
      .req_mem_address(req_mem_address), .req_mem_byte(req_mem_byte),
      .req_console_value(req_console_value), .csr_write(csr_write),
      .csr_index(csr_index), .csr_data(csr_data), .cmd(cmd), .sts(sts),
      .clear_done(clear_done), .rsp_program_counter(rsp_program_counter),
      .rsp_halted(rsp_halted), .rsp_console_kind(rsp_console_kind),
      .rsp_console_out(rsp_console_out), .rsp_input_taken(rsp_input_taken),
      .rsp_status(rsp_status), .rsp_stack_overflow(rsp_stack_overflow),
      .rsp_stack_underflow(rsp_stack_underflow)
   );
endmodule
`default_nettype wire

FILE: rtl/rmes_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
`default_nettype none
module rmes_ram #(
   parameter int Width = 8,
   parameter int Depth = 4096
) (
   input wire logic clock,
   input wire logic we,
   input wire logic [$clog2(Depth)-1:0] addr,
   input wire logic [Width-1:0] wdata,
   output logic [Width-1:0] rdata
);
   logic [Width-1:0] mem [Depth];
   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata <= mem[addr];
   end
endmodule
`default_nettype wire

FILE: rtl/rmes_ctrl.sv
// Controller: sequences fetch, execute, memory access and division.
// Depends on rmes_pkg.
`default_nettype none
module rmes_ctrl (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   output logic req_stall,
   input wire logic [1:0] req_operation,
   output logic rsp_valid,
   input wire logic rsp_stall,
   input wire logic clear_done,
   output rmes_pkg::cmd_type cmd,
   input rmes_pkg::sts_type sts
);
   import rmes_pkg::*;

   typedef enum logic [8:0] {
      S_CLEAR = 9'b000000001,
      S_IDLE = 9'b000000010,
      S_FADDR = 9'b000000100,
      S_FBYTE = 9'b000001000,
      S_EXEC = 9'b000010000,
      S_MEM = 9'b000100000,
      S_DIV = 9'b001000000,
      S_DONE = 9'b010000000,
      S_OUT = 9'b100000000
   } state_type;

   state_type state_ff, state_in;
   logic [3:0] cnt_ff, cnt_in;
   logic out_full_ff, out_full_in;
   logic take;

   assign take = req_valid && !req_stall;
   assign req_stall = !(state_ff == S_IDLE || state_ff == S_OUT) ||
                      (out_full_ff && rsp_stall);
   assign rsp_valid = out_full_ff;

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      out_full_in = out_full_ff && rsp_stall;
      cmd = '0;
      unique case (state_ff)
         S_CLEAR: begin
            if (clear_done) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE, S_OUT: begin
            if (take) begin
               cmd.capture = 1'b1;
               cmd.clr_out = 1'b1;
               if (req_operation == OP_LOAD) begin
                  cmd.mem_load = 1'b1;
                  state_in = S_DONE;
               end else if (req_operation == OP_STEP && !sts.halted) begin
                  cnt_in = '0;
                  state_in = S_FADDR;
               end else begin
                  cmd.start = (req_operation == OP_START);
                  state_in = S_DONE;
               end
            end else begin
               state_in = S_IDLE;
            end
         end
         S_FADDR: begin
            cmd.fetch_addr = 1'b1;
            state_in = S_FBYTE;
         end
         S_FBYTE: begin
            cmd.fetch_byte = 1'b1;
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == 4'd11) begin
               state_in = S_EXEC;
            end else begin
               state_in = S_FADDR;
            end
         end
         S_EXEC: begin
            cmd.exec = 1'b1;
            cnt_in = '0;
            if (sts.is_div) begin
               cmd.div_start = 1'b1;
               state_in = S_DIV;
            end else if (sts.is_load || sts.is_store) begin
               state_in = S_MEM;
            end else begin
               cmd.commit = 1'b1;
               state_in = S_DONE;
            end
         end
         S_MEM: begin
            cmd.mem_addr = 1'b1;
            cmd.mem_byte = cnt_ff[0];
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == {sts.nbytes, 1'b0} - 4'd1) begin
               cmd.commit = 1'b1;
               state_in = S_DONE;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_done) begin
               cmd.commit = 1'b1;
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!out_full_ff || !rsp_stall) begin
               out_full_in = 1'b1;
               state_in = S_OUT;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         cnt_ff <= '0;
         out_full_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         out_full_ff <= out_full_in;
      end
   end

   a_no_take_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FADDR || state_ff == S_EXEC) |-> req_stall)
      else $error("request taken while busy");
   a_commit_once: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> !cmd.commit)
      else $error("double commit");
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid)
      else $error("result dropped");
endmodule
`default_nettype wire

FILE: rtl/rmes_dp.sv
// Datapath: register file, byte memory, decode, ALU and serial divider.
// Depends on rmes_pkg and rmes_ram.
`default_nettype none
module rmes_dp (
   input wire logic clock,
   input wire logic reset,
   input wire logic [1:0] req_operation,
   input wire logic [rmes_pkg::AddrW-1:0] req_mem_address,
   input wire logic [7:0] req_mem_byte,
   input wire logic signed [31:0] req_console_value,
   input wire logic csr_write,
   input wire logic csr_index,
   input wire logic [rmes_pkg::AddrW-1:0] csr_data,
   input rmes_pkg::cmd_type cmd,
   output rmes_pkg::sts_type sts,
   output logic clear_done,
   output logic [rmes_pkg::AddrW-1:0] rsp_program_counter,
   output logic rsp_halted,
   output logic [1:0] rsp_console_kind,
   output logic signed [31:0] rsp_console_out,
   output logic rsp_input_taken,
   output logic [2:0] rsp_status,
   output logic rsp_stack_overflow,
   output logic rsp_stack_underflow
);
   import rmes_pkg::*;

   logic [AddrW-1:0] pstart_ff, pend_ff;
   logic [31:0] regs_ff [NumRegs];
   logic halt_ff;
   logic [31:0] cv_ff;
   logic [95:0] ir_ff;
   logic [3:0] cnt_ff;
   logic [AddrW:0] clr_ff;
   logic clearing;

   logic [AddrW-1:0] ram_addr;
   logic ram_we;
   logic [7:0] ram_wdata, ram_rdata;

   logic [31:0] opc, a1, a2;
   logic a1ok, a2ok;
   logic [31:0] ra1, ra2;
   logic [31:0] pc_next;
   logic [AddrW-1:0] pc_base;

   // pending execution results
   logic [31:0] wval_in;
   logic [IdxW-1:0] wreg_ff, wreg_in;
   logic wen_in;
   logic [31:0] pcn_ff, pcn_in;
   logic [2:0] st_ff, st_in;
   logic [1:0] ck_in;
   logic [31:0] co_in;
   logic it_in, halt_in;
   logic isdiv_ff, isld_ff, isst_ff;
   logic [2:0] nb_ff;
   logic [AddrW-1:0] maddr_ff;
   logic [31:0] sdata_ff;
   logic [31:0] ldata_ff;
   logic wbyte_ff;
   logic [1:0] mcnt_ff;

   // divider
   logic [31:0] dq_ff, dr_ff, dd_ff;
   logic dneg_ff;
   logic [5:0] dcnt_ff;
   logic [32:0] dsub;

   assign clearing = !clr_ff[AddrW];
   assign clear_done = clr_ff[AddrW];

   rmes_ram #(.Width(8), .Depth(MemBytes)) u_mem (
      .clock(clock), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
   );

   assign pc_base = regs_ff[REG_PC][AddrW-1:0];
   assign pc_next = regs_ff[REG_PC] + 32'd12;
   assign opc = ir_ff[31:0];
   assign a1 = ir_ff[63:32];
   assign a2 = ir_ff[95:64];
   assign a1ok = a1 < 32'(NumRegs);
   assign a2ok = a2 < 32'(NumRegs);
   assign ra1 = !a1ok ? '0 : (a1[IdxW-1:0] == REG_PC) ? pc_next : regs_ff[a1[RegW-1:0]];
   assign ra2 = !a2ok ? '0 : (a2[IdxW-1:0] == REG_PC) ? pc_next : regs_ff[a2[RegW-1:0]];

   always_comb begin
      ram_we = 1'b0;
      ram_addr = pc_base + AddrW'(cnt_ff);
      ram_wdata = '0;
      if (clearing) begin
         ram_we = 1'b1;
         ram_addr = clr_ff[AddrW-1:0];
         ram_wdata = '0;
      end else if (cmd.mem_load) begin
         ram_we = 1'b1;
         ram_addr = req_mem_address;
         ram_wdata = req_mem_byte;
      end else if (cmd.mem_addr) begin
         ram_addr = maddr_ff + AddrW'(mcnt_ff);
         ram_we = isst_ff && !cmd.mem_byte && st_ff == ST_OK;
         ram_wdata = sdata_ff[8*mcnt_ff +: 8];
      end
   end

   // decode and execute
   always_comb begin
      logic [31:0] addr;
      logic aok;
      logic [4:0] o;
      logic signed [31:0] sx, sy;
      logic c;
      addr = '0;
      aok = 1'b1;
      o = opc[4:0];
      sx = ra1;
      sy = ra2;
      c = 1'b0;
      wval_in = '0;
      wreg_in = a1[IdxW-1:0];
      wen_in = 1'b0;
      pcn_in = pc_next;
      st_in = ST_OK;
      ck_in = CK_NONE;
      co_in = '0;
      it_in = 1'b0;
      halt_in = 1'b0;
      if (opc >= 32'd9 && opc <= 32'd12) begin
         addr = a2;
      end else if (opc >= 32'd22 && opc <= 32'd25) begin
         addr = ra2;
         aok = a2ok;
      end
      if (opc == 32'd0 || opc > 32'd30) begin
         st_in = ST_BAD_OP;
      end else begin
         case (o)
            5'd1: pcn_in = a2;
            5'd2: if (!a2ok) st_in = ST_BAD_ARG; else pcn_in = ra2;
            5'd3, 5'd4, 5'd5, 5'd6: begin
               if (!a1ok) begin
                  st_in = ST_BAD_ARG;
               end else begin
                  case (o)
                     5'd3: c = sx != 0;
                     5'd4: c = sx > 0;
                     5'd5: c = sx < 0;
                     default: c = sx == 0;
                  endcase
                  if (c) pcn_in = a2;
               end
            end
            5'd7: begin
               if (!a1ok || !a2ok) st_in = ST_BAD_ARG;
               else begin wen_in = 1'b1; wval_in = ra2; end
            end
            5'd8: begin
               if (!a1ok) st_in = ST_BAD_ARG;
               else begin wen_in = 1'b1; wval_in = a2; end
            end
            5'd9, 5'd10, 5'd22, 5'd23: begin
               if (!a1ok || !aok || addr[31] || addr > 32'(MemBytes - 4))
                  st_in = ST_BAD_ARG;
            end
            5'd11, 5'd12, 5'd24, 5'd25: begin
               if (!a1ok || !aok || addr[31] || addr > 32'(MemBytes - 1))
                  st_in = ST_BAD_ARG;
            end
            5'd13, 5'd14, 5'd15, 5'd16, 5'd17, 5'd18, 5'd19, 5'd20: begin
               if (o == 5'd14) sy = a2;
               if (!a1ok || (o != 5'd14 && !a2ok)) begin
                  st_in = ST_BAD_ARG;
               end else begin
                  wen_in = 1'b1;
                  case (o)
                     5'd13, 5'd14: wval_in = sx + sy;
                     5'd15: wval_in = sx - sy;
                     5'd16: wval_in = sx * sy;
                     5'd17: begin
                        wen_in = 1'b0;
                        if (sy == 0) st_in = ST_DIV_ZERO;
                     end
                     5'd18: wval_in = {31'd0, sx != 0 && sy != 0};
                     5'd19: wval_in = {31'd0, sx != 0 || sy != 0};
                     default: wval_in = (sx == sy) ? 32'd0 : (sx > sy) ? 32'd1 : '1;
                  endcase
               end
            end
            5'd21: begin
               wreg_in = REG_CON;
               if (a2 == 32'd1) begin
                  ck_in = CK_INT; co_in = regs_ff[REG_CON];
               end else if (a2 == 32'd2) begin
                  wen_in = 1'b1; wval_in = cv_ff; it_in = 1'b1;
               end else if (a2 == 32'd3) begin
                  ck_in = CK_CHAR; co_in = {24'd0, regs_ff[REG_CON][7:0]};
               end else if (a2 == 32'd4) begin
                  wen_in = 1'b1; it_in = 1'b1;
                  wval_in = {regs_ff[REG_CON][31:8], cv_ff[7:0]};
               end else if (a2 == 32'(TrapNl)) begin
                  ck_in = CK_NL;
               end else begin
                  halt_in = 1'b1;
               end
            end
            default: st_in = ST_UNIMPL;
         endcase
      end
   end

   assign dsub = {dr_ff[30:0], dq_ff[31]} - {1'b0, dd_ff};

   assign sts.halted = halt_ff;
   assign sts.is_div = opc == 32'd17 && st_in == ST_OK;
   assign sts.is_load = st_in == ST_OK &&
      (opc == 32'd10 || opc == 32'd12 || opc == 32'd23 || opc == 32'd25);
   assign sts.is_store = st_in == ST_OK &&
      (opc == 32'd9 || opc == 32'd11 || opc == 32'd22 || opc == 32'd24);
   assign sts.nbytes = nb_ff;
   assign sts.div_done = dcnt_ff == 6'd32;

   always_ff @(posedge clock) begin
      logic [31:0] ea;
      ea = (opc >= 32'd22) ? ra2 : a2;
      if (reset) begin
         clr_ff <= '0;
         pstart_ff <= '0;
         pend_ff <= '0;
         halt_ff <= 1'b0;
         for (int i = 0; i < NumRegs; i++) regs_ff[i] <= '0;
      end else begin
         if (clearing) clr_ff <= clr_ff + 1'b1;
         if (csr_write) begin
            if (csr_index == CSR_START) pstart_ff <= csr_data;
            else pend_ff <= csr_data;
         end
         if (cmd.start) begin
            regs_ff[REG_PC] <= 32'(pstart_ff);
            regs_ff[REG_LIM] <= 32'(pend_ff);
            regs_ff[REG_SP] <= 32'(MemBytes - 1);
            regs_ff[REG_BASE] <= 32'(MemBytes - 1);
            halt_ff <= 1'b0;
         end
         if (cmd.exec && halt_in) halt_ff <= 1'b1;
         if (cmd.commit) begin
            regs_ff[REG_PC] <= pcn_ff;
            if (cmd.exec) regs_ff[REG_PC] <= pcn_in;
            if (cmd.exec && wen_in) regs_ff[wreg_in[RegW-1:0]] <= wval_in;
            if (!cmd.exec && isld_ff)
               regs_ff[wreg_ff[RegW-1:0]] <= wbyte_ff ?
                  {24'd0, ram_rdata} : {ram_rdata, ldata_ff[31:8]};
            if (!cmd.exec && isdiv_ff)
               regs_ff[wreg_ff[RegW-1:0]] <= dneg_ff ? -dq_ff : dq_ff;
         end
      end
      if (cmd.capture) begin
         cv_ff <= req_console_value;
         cnt_ff <= '0;
      end
      if (cmd.fetch_byte) begin
         ir_ff <= {ram_rdata, ir_ff[95:8]};
         cnt_ff <= cnt_ff + 4'd1;
      end
      if (cmd.clr_out) begin
         rsp_console_kind <= CK_NONE;
         rsp_console_out <= '0;
         rsp_input_taken <= 1'b0;
         rsp_status <= ST_OK;
         rsp_stack_overflow <= 1'b0;
         rsp_stack_underflow <= 1'b0;
         if (req_operation == OP_STEP && !halt_ff) begin
            rsp_stack_overflow <= $signed({regs_ff[REG_SP][31], regs_ff[REG_SP]}) <=
               $signed({regs_ff[REG_LIM][31], regs_ff[REG_LIM]}) + 33'sd32;
            rsp_stack_underflow <= $signed(regs_ff[REG_SP]) >
               $signed(regs_ff[REG_BASE]);
         end
      end
      if (cmd.exec) begin
         rsp_console_kind <= ck_in;
         rsp_console_out <= co_in;
         rsp_input_taken <= it_in;
         rsp_status <= st_in;
         st_ff <= st_in;
         pcn_ff <= pcn_in;
         wreg_ff <= wreg_in;
         isdiv_ff <= sts.is_div;
         isld_ff <= sts.is_load;
         isst_ff <= sts.is_store;
         wbyte_ff <= !(opc == 32'd9 || opc == 32'd10 || opc == 32'd22 || opc == 32'd23);
         nb_ff <= (opc == 32'd9 || opc == 32'd10 || opc == 32'd22 || opc == 32'd23)
            ? 3'd4 : 3'd1;
         maddr_ff <= ea[AddrW-1:0];
         sdata_ff <= ra1;
         mcnt_ff <= '0;
         dq_ff <= ra1[31] ? -ra1 : ra1;
         dd_ff <= ra2[31] ? -ra2 : ra2;
         dneg_ff <= ra1[31] ^ ra2[31];
         dr_ff <= '0;
         dcnt_ff <= '0;
      end
      if (cmd.mem_addr && cmd.mem_byte) begin
         ldata_ff <= {ram_rdata, ldata_ff[31:8]};
         mcnt_ff <= mcnt_ff + 2'd1;
      end
      if (cmd.div_step && dcnt_ff != 6'd32) begin
         if (!dsub[32]) begin
            dr_ff <= dsub[31:0];
            dq_ff <= {dq_ff[30:0], 1'b1};
         end else begin
            dr_ff <= {dr_ff[30:0], dq_ff[31]};
            dq_ff <= {dq_ff[30:0], 1'b0};
         end
         dcnt_ff <= dcnt_ff + 6'd1;
      end
   end

   assign rsp_program_counter = regs_ff[REG_PC][AddrW-1:0];
   assign rsp_halted = halt_ff;

   a_clear_no_cmd: assert property (@(posedge clock) disable iff (reset)
      clearing |-> !cmd.capture)
      else $error("request during memory clear");
   a_div_ok: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |-> st_in == ST_OK)
      else $error("divide started on error");
   a_mem_excl: assert property (@(posedge clock) disable iff (reset)
      cmd.exec |-> !(sts.is_load && sts.is_store))
      else $error("load and store together");
endmodule
`default_nettype wire

FILE: bench/tb_register_machine_execute_step.sv
// Self-checking bench for register_machine_execute_step: loads small random
// programs, starts the machine and steps it, predicting each response in a scoreboard.
// Depends on rmes_pkg and the block's RTL.
`timescale 1ns / 1ps
`default_nettype none
module tb_register_machine_execute_step;
   import rmes_pkg::*;

   typedef struct packed {
      logic [11:0] pc;
      logic halted;
      logic [1:0] kind;
      logic [31:0] cout;
      logic taken;
      logic [2:0] status;
      logic ovf;
      logic unf;
   } step_result_type;

   typedef enum int {
      I_JMP = 1, I_JMPR = 2, I_BNZ = 3, I_BGT = 4, I_BLT = 5, I_BZ = 6, I_MOV = 7,
      I_MOVI = 8, I_STW = 9, I_LDW = 10, I_STB = 11, I_LDB = 12, I_ADD = 13,
      I_ADDI = 14, I_SUB = 15, I_MUL = 16, I_DIV = 17, I_AND = 18, I_OR = 19,
      I_CMP = 20, I_TRAP = 21, I_STWR = 22, I_LDWR = 23, I_STBR = 24, I_LDBR = 25
   } instr_type;

   localparam int TrapPutInt = 1;
   localparam int TrapGetInt = 2;
   localparam int TrapPutChar = 3;
   localparam int TrapGetChar = 4;

   class machine_scoreboard;
      logic [31:0] regs[NumRegs];
      logic [7:0] mem[MemBytes];
      logic halt;
      logic [11:0] prog_start, prog_end;
      step_result_type pending[$];
      int fails;

      function new();
         foreach (regs[i]) regs[i] = '0;
         foreach (mem[i]) mem[i] = '0;
         halt = 1'b0;
         prog_start = '0;
         prog_end = '0;
         fails = 0;
      endfunction

      function void set_cfg(logic idx, logic [11:0] val);
         if (idx == CSR_START) prog_start = val;
         else prog_end = val;
      endfunction

      function logic [31:0] word_at(logic [31:0] base);
         logic [31:0] w;
         for (int i = 0; i < 4; i++) w[8*i +: 8] = mem[(base + i) % MemBytes];
         return w;
      endfunction

      function bit addr_fits(logic [31:0] a, int n);
         return !a[31] && ({1'b0, a} + n <= MemBytes);
      endfunction

      function void execute(logic [31:0] cv, inout step_result_type r);
         logic [31:0] op, a1, a2, addr, x, y;
         logic [2:0] st;
         bit aok, rok1, rok2;
         int nb;
         longint p, q;
         r.ovf = $signed(regs[REG_SP]) <= longint'($signed(regs[REG_LIM])) + StackMargin;
         r.unf = $signed(regs[REG_SP]) > $signed(regs[REG_BASE]);
         op = word_at(regs[REG_PC] % MemBytes);
         a1 = word_at(regs[REG_PC] % MemBytes + 4);
         a2 = word_at(regs[REG_PC] % MemBytes + 8);
         regs[REG_PC] = regs[REG_PC] + 12;
         rok1 = a1 < NumRegs;
         rok2 = a2 < NumRegs;
         st = ST_OK;
         aok = 1;
         addr = '0;
         if (op >= I_STW && op <= I_LDB) addr = a2;
         else if (op >= I_STWR && op <= I_LDBR) begin
            if (rok2) addr = regs[a2];
            else aok = 0;
         end
         nb = (op == I_STB || op == I_LDB || op == I_STBR || op == I_LDBR) ? 1 : 4;
         case (op)
            I_JMP: regs[REG_PC] = a2;
            I_JMPR: if (!rok2) st = ST_BAD_ARG; else regs[REG_PC] = regs[a2];
            I_BNZ, I_BGT, I_BLT, I_BZ: begin
               if (!rok1) st = ST_BAD_ARG;
               else if ((op == I_BNZ && regs[a1] != 0) ||
                        (op == I_BGT && $signed(regs[a1]) > 0) ||
                        (op == I_BLT && $signed(regs[a1]) < 0) ||
                        (op == I_BZ && regs[a1] == 0)) regs[REG_PC] = a2;
            end
            I_MOV: if (!rok1 || !rok2) st = ST_BAD_ARG; else regs[a1] = regs[a2];
            I_MOVI: if (!rok1) st = ST_BAD_ARG; else regs[a1] = a2;
            I_STW, I_STWR, I_STB, I_STBR, I_LDW, I_LDWR, I_LDB, I_LDBR: begin
               if (!rok1 || !aok || !addr_fits(addr, nb)) st = ST_BAD_ARG;
               else if (op == I_STW || op == I_STWR || op == I_STB || op == I_STBR) begin
                  for (int i = 0; i < nb; i++) mem[addr + i] = regs[a1][8*i +: 8];
               end else begin
                  x = '0;
                  for (int i = 0; i < nb; i++) x[8*i +: 8] = mem[addr + i];
                  regs[a1] = x;
               end
            end
            I_ADD, I_ADDI, I_SUB, I_MUL, I_DIV, I_AND, I_OR, I_CMP: begin
               if (!rok1 || (op != I_ADDI && !rok2)) st = ST_BAD_ARG;
               else begin
                  x = regs[a1];
                  y = (op == I_ADDI) ? a2 : regs[a2];
                  p = $signed(x);
                  q = $signed(y);
                  case (op)
                     I_ADD, I_ADDI: regs[a1] = x + y;
                     I_SUB: regs[a1] = x - y;
                     I_MUL: regs[a1] = x * y;
                     I_DIV: begin
                        if (y == 0) st = ST_DIV_ZERO;
                        else regs[a1] = 32'(p / q);
                     end
                     I_AND: regs[a1] = {31'd0, x != 0 && y != 0};
                     I_OR: regs[a1] = {31'd0, x != 0 || y != 0};
                     default: regs[a1] = (p == q) ? 32'd0 : (p > q) ? 32'd1 : 32'hFFFF_FFFF;
                  endcase
               end
            end
            I_TRAP: begin
               if (a2 == TrapPutInt) begin
                  r.kind = CK_INT;
                  r.cout = regs[REG_CON];
               end else if (a2 == TrapGetInt) begin
                  regs[REG_CON] = cv;
                  r.taken = 1'b1;
               end else if (a2 == TrapPutChar) begin
                  r.kind = CK_CHAR;
                  r.cout = {24'd0, regs[REG_CON][7:0]};
               end else if (a2 == TrapGetChar) begin
                  regs[REG_CON][7:0] = cv[7:0];
                  r.taken = 1'b1;
               end else if (a2 == TrapNl) r.kind = CK_NL;
               else halt = 1'b1;
            end
            26, 27, 28, 29, 30: st = ST_UNIMPL;
            default: st = ST_BAD_OP;
         endcase
         r.status = st;
      endfunction

      function void note(logic [1:0] op, logic [11:0] a, logic [7:0] b, logic [31:0] cv);
         step_result_type r;
         r = '0;
         if (op == OP_LOAD) mem[a] = b;
         else if (op == OP_START) begin
            regs[REG_PC] = 32'(prog_start);
            regs[REG_LIM] = 32'(prog_end);
            regs[REG_SP] = MemBytes - 1;
            regs[REG_BASE] = MemBytes - 1;
            halt = 1'b0;
         end else if (op == OP_STEP && !halt) execute(cv, r);
         r.pc = 12'(regs[REG_PC] % MemBytes);
         r.halted = halt;
         pending.push_back(r);
      endfunction

      function void report(string what, longint e, longint a);
         fails++;
         if (fails <= 10) $display("mismatch %s: expected %0h got %0h", what, e, a);
      endfunction

      function void check(step_result_type a);
         step_result_type e;
         if (pending.size() == 0) begin
            report("unexpected response", 0, 1);
            return;
         end
         e = pending.pop_front();
         if (e.pc !== a.pc) report("program_counter", e.pc, a.pc);
         if (e.halted !== a.halted) report("halted", e.halted, a.halted);
         if (e.kind !== a.kind) report("console_kind", e.kind, a.kind);
         if (e.cout !== a.cout) report("console_out", e.cout, a.cout);
         if (e.taken !== a.taken) report("input_taken", e.taken, a.taken);
         if (e.status !== a.status) report("status", e.status, a.status);
         if (e.ovf !== a.ovf) report("stack_overflow", e.ovf, a.ovf);
         if (e.unf !== a.unf) report("stack_underflow", e.unf, a.unf);
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic [1:0] req_operation = '0;
   logic [11:0] req_mem_address = '0;
   logic [7:0] req_mem_byte = '0;
   logic signed [31:0] req_console_value = '0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic [11:0] rsp_program_counter;
   logic rsp_halted;
   logic [1:0] rsp_console_kind;
   logic signed [31:0] rsp_console_out;
   logic rsp_input_taken;
   logic [2:0] rsp_status;
   logic rsp_stack_overflow;
   logic rsp_stack_underflow;
   logic csr_write = 0;
   logic csr_index = 0;
   logic [11:0] csr_data = '0;

   machine_scoreboard sb = new();
   int idle_pct = 0;
   int stall_pct = 0;
   int sent = 0;

   register_machine_execute_step dut (.*);

   always #5 clock = ~clock;

   always @(negedge clock) rsp_stall <= ($urandom_range(99) < stall_pct);

   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall)
         sb.note(req_operation, req_mem_address, req_mem_byte, req_console_value);
      if (!reset && rsp_valid && !rsp_stall)
         sb.check({rsp_program_counter, rsp_halted, rsp_console_kind, rsp_console_out,
                   rsp_input_taken, rsp_status, rsp_stack_overflow, rsp_stack_underflow});
   end

   task automatic send(logic [1:0] op, logic [11:0] a, logic [7:0] b);
      @(negedge clock);
      while ($urandom_range(99) < idle_pct) begin
         req_valid = 0;
         @(negedge clock);
      end
      req_valid = 1;
      req_operation = op;
      req_mem_address = a;
      req_mem_byte = b;
      req_console_value = $urandom;
      do @(posedge clock); while (req_stall);
      sent++;
   endtask

   task automatic drain_and_configure(logic [11:0] ps, logic [11:0] pe);
      @(negedge clock);
      req_valid = 0;
      while (sb.pending.size() != 0) @(negedge clock);
      repeat (60) @(negedge clock);
      csr_write = 1;
      csr_index = CSR_START;
      csr_data = ps;
      @(negedge clock);
      csr_index = CSR_END;
      csr_data = pe;
      sb.set_cfg(CSR_START, ps);
      @(negedge clock);
      csr_write = 0;
      sb.set_cfg(CSR_END, pe);
   endtask

   function automatic logic [31:0] pick_reg();
      int r;
      r = $urandom_range(99);
      if (r < 88) return $urandom_range(NumRegs - 1);
      if (r < 94) return $urandom_range(15, NumRegs);
      return $urandom;
   endfunction

   function automatic logic [31:0] pick_addr();
      case ($urandom_range(9))
         0: return 0;
         1: return MemBytes - 4;
         2: return $urandom_range(MemBytes - 1, MemBytes - 3);
         3: return MemBytes;
         4: return 32'hFFFF_FFFC;
         5: return $urandom;
         default: return $urandom_range(MemBytes - 1, 2048);
      endcase
   endfunction

   function automatic logic [31:0] pick_value();
      case ($urandom_range(7))
         0: return 0;
         1: return 32'hFFFF_FFFF;
         2: return 32'h8000_0000;
         3: return 32'h7FFF_FFFF;
         4: return pick_addr();
         5: return $urandom_range(NumRegs + 3);
         default: return $urandom;
      endcase
   endfunction

   task automatic run_program(logic [11:0] ps, int n);
      logic [31:0] w[3];
      int r;
      for (int k = 0; k < n; k++) begin
         r = $urandom_range(99);
         if (r < 90) w[0] = $urandom_range(I_LDBR, I_JMP);
         else if (r < 95) w[0] = $urandom_range(30, 26);
         else if (r < 97) w[0] = 0;
         else w[0] = (r == 97) ? 32'd31 : $urandom;
         w[1] = pick_reg();
         case (w[0])
            I_JMP, I_BNZ, I_BGT, I_BLT, I_BZ:
               w[2] = ($urandom_range(9) < 8) ? ps + 12 * $urandom_range(n) : $urandom;
            I_MOVI, I_ADDI: w[2] = pick_value();
            I_STW, I_LDW, I_STB, I_LDB: w[2] = pick_addr();
            I_TRAP: begin
               r = $urandom_range(13);
               w[2] = (r < 2) ? TrapPutInt : (r < 4) ? TrapGetInt : (r < 6) ? TrapPutChar :
                      (r < 8) ? TrapGetChar : (r < 10) ? TrapNl : (r < 12) ? 0 : $urandom;
            end
            default: w[2] = pick_reg();
         endcase
         for (int j = 0; j < 3; j++)
            for (int b = 0; b < 4; b++)
               send(OP_LOAD, 12'(ps + 12 * k + 4 * j + b), w[j][8*b +: 8]);
      end
      send(OP_START, 12'($urandom), 8'($urandom));
      repeat (2 * n + $urandom_range(4)) send(OP_STEP, 12'($urandom), 8'($urandom));
   endtask

   initial begin
      #10ms;
      $display("Verification failed");
      $finish;
   end

   initial begin
      logic [11:0] ps, pe;
      int prog;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 0;
      drain_and_configure(12'd0, 12'd0);
      send(2'd3, 12'hFFF, 8'hFF);
      send(OP_STEP, 12'd0, 8'd0);
      send(OP_LOAD, 12'hFFF, 8'hFF);
      send(OP_LOAD, 12'd0, 8'(I_TRAP));
      send(OP_LOAD, 12'd8, 8'(TrapNl));
      send(OP_STEP, 12'd0, 8'd0);
      send(OP_START, 12'd0, 8'd0);
      send(OP_STEP, 12'd0, 8'd0);
      send(OP_STEP, 12'd0, 8'd0);
      send(OP_LOAD, 12'd12, 8'h80);
      send(OP_STEP, 12'd0, 8'd0);
      send(OP_START, 12'd0, 8'd0);
      send(OP_STEP, 12'd0, 8'd0);
      prog = 0;
      while (sent < 1350) begin
         ps = (prog % 5 == 1) ? 12'hFFF : (prog % 5 == 2) ? 12'h000 : 12'($urandom);
         pe = (prog % 3 == 0) ? 12'hFFF : (prog % 3 == 1) ? 12'h000 : 12'($urandom);
         drain_and_configure(ps, pe);
         idle_pct = (sent * 4 / 1350 == 1 || sent * 4 / 1350 == 3) ? 64 : 0;
         stall_pct = (sent * 4 / 1350 == 2) ? 64 : 0;
         if (sent * 4 / 1350 >= 3) begin
            idle_pct = 29;
            stall_pct = 29;
         end
         if ($urandom_range(9) == 0)
            repeat ($urandom_range(6, 1)) send(2'($urandom), 12'($urandom), 8'($urandom));
         run_program(ps, $urandom_range(6, 2));
         prog++;
      end
      @(negedge clock);
      req_valid = 0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (sb.fails == 0) $display("Verification passed");
      else $display("Verification failed");
      $finish;
   end
endmodule
`default_nettype wire

FILE: sim.f
rtl/rmes_pkg.sv
rtl/rmes_ram.sv
rtl/rmes_ctrl.sv
rtl/rmes_dp.sv
rtl/register_machine_execute_step.sv
bench/tb_register_machine_execute_step.sv
